>>> sv/ops_pkg.sv
// Shared types, widths and arithmetic helpers for the pixel-to-sphere pipeline.
// No dependencies.
`default_nettype none

package ops_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_INV_FX      = 3'd0,
    REG_INV_SKEW    = 3'd1,
    REG_INV_CX_TERM = 3'd2,
    REG_INV_FY      = 3'd3,
    REG_INV_CY_TERM = 3'd4,
    REG_MIRROR_XI   = 3'd5
  } reg_idx_t;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int XI_W   = 18;
  localparam int COORD_W = 12;

  localparam int NORM_W  = 21;   // normalized magnitude width
  localparam int RAD_W   = 44;   // radicand width (non-negative part)
  localparam int ROOT_W  = 22;   // floor sqrt width
  localparam int DEN_W   = 44;
  localparam int XC_W    = 39;   // xi * c
  localparam int NUM_W   = 40;
  localparam int DVD_W   = 62;   // v*num + den/2
  localparam int QUO_W   = 22;
  localparam int OUT_W   = 18;
  localparam int LANES   = 3;    // x, y, z
  localparam int STEPS   = 2;    // iterations per pipeline stage

  localparam logic signed [23:0] OUT_MAX = 24'sd131071;
  localparam logic signed [23:0] OUT_MIN = -24'sd131072;

  typedef struct packed {
    logic signed [31:0]  inv_fx;
    logic signed [31:0]  inv_skew;
    logic signed [31:0]  inv_cx_term;
    logic signed [31:0]  inv_fy;
    logic signed [31:0]  inv_cy_term;
    logic [XI_W-1:0]     mirror_xi;
  } cfg_t;

  typedef struct packed {
    logic keep;
    logic nx;
    logic ny;
    logic clamped;
  } flags_t;

  // payload that rides alongside the square root
  typedef struct packed {
    logic [NORM_W-1:0] a;
    logic [NORM_W-1:0] b;
    logic [NORM_W-1:0] c;
    logic [DEN_W-1:0]  den;
    logic [XC_W-1:0]   xc;
    flags_t            flags;
  } sqsb_t;

  typedef struct packed {
    logic [RAD_W+1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [DEN_W-1:0]  rem;
    logic [QUO_W-1:0]  low;
    logic [QUO_W-1:0]  quo;
  } dv_t;

  // one bit of restoring square root at bit position j
  function automatic sq_t sqrt_step(sq_t s, int j);
    logic [RAD_W+1:0] trial;
    sq_t r;
    trial = ({{(RAD_W+2-ROOT_W){1'b0}}, s.root} << (j + 1)) + ((RAD_W+2)'(1) << (2 * j));
    r = s;
    if (trial <= s.rem) begin
      r.rem  = s.rem - trial;
      r.root = s.root | (ROOT_W'(1) << j);
    end
    return r;
  endfunction

  // one quotient bit of restoring division
  function automatic dv_t div_step(dv_t s, logic [DEN_W-1:0] den);
    logic [DEN_W:0] r;
    dv_t o;
    r = {s.rem, s.low[QUO_W-1]};
    o.low = {s.low[QUO_W-2:0], 1'b0};
    if (r >= {1'b0, den}) begin
      o.rem = DEN_W'(r - {1'b0, den});
      o.quo = {s.quo[QUO_W-2:0], 1'b1};
    end else begin
      o.rem = r[DEN_W-1:0];
      o.quo = {s.quo[QUO_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [OUT_W-1:0] sat18(logic signed [23:0] v);
    logic [OUT_W-1:0] r;
    if (v > OUT_MAX) r = OUT_MAX[OUT_W-1:0];
    else if (v < OUT_MIN) r = OUT_MIN[OUT_W-1:0];
    else r = v[OUT_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/ops_cfg.sv
// Configuration register file for the unprojection pipeline.
// Depends on ops_pkg.
`default_nettype none

module ops_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [ops_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [ops_pkg::CFG_DW-1:0]  cfg_wdata,
  output ops_pkg::cfg_t                    cfg
);
  import ops_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inv_fx      <= 32'sd16777216;
      cfg.inv_skew    <= '0;
      cfg.inv_cx_term <= '0;
      cfg.inv_fy      <= 32'sd16777216;
      cfg.inv_cy_term <= '0;
      cfg.mirror_xi   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_INV_FX:      cfg.inv_fx      <= cfg_wdata;
        REG_INV_SKEW:    cfg.inv_skew    <= cfg_wdata;
        REG_INV_CX_TERM: cfg.inv_cx_term <= cfg_wdata;
        REG_INV_FY:      cfg.inv_fy      <= cfg_wdata;
        REG_INV_CY_TERM: cfg.inv_cy_term <= cfg_wdata;
        REG_MIRROR_XI:   cfg.mirror_xi   <= cfg_wdata[XI_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/ops_sqrt.sv
// Pipelined restoring integer square root, two result bits per stage.
// Depends on ops_pkg; carries an sqsb_t payload alongside.
`default_nettype none

module ops_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        ce,
  input  wire logic                        in_vld,
  input  wire logic [ops_pkg::RAD_W-1:0]   rad,
  input  ops_pkg::sqsb_t                   in_sb,
  output logic                             out_vld,
  output logic [ops_pkg::ROOT_W-1:0]       root,
  output ops_pkg::sqsb_t                   out_sb
);
  import ops_pkg::*;

  localparam int NST = ROOT_W / STEPS;

  sq_t   stg  [0:NST];
  sqsb_t sbs  [0:NST];
  logic  vlds [0:NST];

  assign stg[0]  = '{rem: {2'b00, rad}, root: '0};
  assign sbs[0]  = in_sb;
  assign vlds[0] = in_vld;

  for (genvar g = 0; g < NST; g++) begin : g_st
    sq_t   nxt;
    sq_t   pipe;
    sqsb_t sb;
    logic  vld;

    always_comb begin
      nxt = sqrt_step(stg[g], ROOT_W - 1 - STEPS * g);
      nxt = sqrt_step(nxt, ROOT_W - 2 - STEPS * g);
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        pipe <= nxt;
        sb   <= sbs[g];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vld <= 1'b0;
      else if (ce) vld <= vlds[g];
    end

    assign stg[g+1]  = pipe;
    assign sbs[g+1]  = sb;
    assign vlds[g+1] = vld;
  end

  assign out_vld = vlds[NST];
  assign root    = stg[NST].root;
  assign out_sb  = sbs[NST];

endmodule

`default_nettype wire

>>> sv/ops_div.sv
// Pipelined restoring divider, three lanes sharing one divisor, two bits per stage.
// Depends on ops_pkg.
`default_nettype none

module ops_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        ce,
  input  wire logic                        in_vld,
  input  wire logic [ops_pkg::DEN_W-1:0]   den,
  input  wire logic [ops_pkg::DVD_W-1:0]   dvd [ops_pkg::LANES],
  input  ops_pkg::flags_t                  in_flags,
  output logic                             out_vld,
  output logic [ops_pkg::QUO_W-1:0]        quo [ops_pkg::LANES],
  output ops_pkg::flags_t                  out_flags
);
  import ops_pkg::*;

  localparam int NST = QUO_W / STEPS;

  dv_t             stg  [0:NST][LANES];
  logic [DEN_W-1:0] dens [0:NST];
  flags_t          fls  [0:NST];
  logic            vlds [0:NST];

  for (genvar l = 0; l < LANES; l++) begin : g_in
    // dividend < den * 2^QUO_W, so the high part starts below den
    assign stg[0][l] = '{rem: DEN_W'(dvd[l][DVD_W-1:QUO_W]),
                         low: dvd[l][QUO_W-1:0], quo: '0};
    assign quo[l] = stg[NST][l].quo;
  end
  assign dens[0] = den;
  assign fls[0]  = in_flags;
  assign vlds[0] = in_vld;

  for (genvar g = 0; g < NST; g++) begin : g_st
    dv_t             pipe [LANES];
    logic [DEN_W-1:0] dn;
    flags_t          fl;
    logic            vld;

    for (genvar l = 0; l < LANES; l++) begin : g_ln
      dv_t nxt;
      always_comb begin
        nxt = div_step(stg[g][l], dens[g]);
        nxt = div_step(nxt, dens[g]);
      end
      always_ff @(posedge clk) begin
        if (ce) pipe[l] <= nxt;
      end
      assign stg[g+1][l] = pipe[l];
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        dn <= dens[g];
        fl <= fls[g];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vld <= 1'b0;
      else if (ce) vld <= vlds[g];
    end

    assign dens[g+1] = dn;
    assign fls[g+1]  = fl;
    assign vlds[g+1] = vld;
  end

  assign out_vld   = vlds[NST];
  assign out_flags = fls[NST];

endmodule

`default_nettype wire

>>> sv/omni_pixel_to_sphere.sv
// Pixel to unit-sphere unprojection (unified omnidirectional camera model).
// One pixel is accepted per clock unless the output stalls, and each gives exactly one
// result after passing 10 front stages (intrinsics, normalize, squares, radicand),
// 11 square-root stages, 3 stages forming numerator and dividends, 11 divider
// stages and the output register. The square root and the three dividers resolve
// two bits per stage, which sets the depth. Back-pressure stalls the whole pipeline
// in place, so nothing is lost or repeated. Registers are read live and must only be
// written while the pipeline is empty. Depends on ops_pkg, ops_cfg, ops_sqrt, ops_div.
`default_nettype none

module omni_pixel_to_sphere #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input stream
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [23:0]                 s_tdata,   // pixel_col[11:0], pixel_row[23:12]
  input  wire logic                        s_tuser,   // keep_pixel
  // output stream
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [55:0]                      m_tdata,   // sphere_x[17:0], sphere_y[35:18],
                                                      // sphere_z[53:36], zero pad[55:54]
  output logic                             m_tuser,   // root_clamped
  // configuration
  input  wire logic                        cfg_we,
  input  wire logic [ops_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [ops_pkg::CFG_DW-1:0]  cfg_wdata
);
  import ops_pkg::*;

  cfg_t cfg;

  ops_cfg u_cfg (
    .clk, .rst, .cfg_we, .cfg_addr, .cfg_wdata, .cfg
  );

  // Global advance: move when the output register is empty or being drained.
  logic ce;
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  // ---------------- stage 1: clamp coordinates, intrinsic products
  logic [COORD_W-1:0] col_c, row_c;
  logic signed [44:0] m_fx, m_sk, m_fy;

  always_comb begin
    col_c = s_tdata[11:0];
    row_c = s_tdata[23:12];
    if ({5'd0, col_c} >= 17'(MAX_DIM)) col_c = COORD_W'(MAX_DIM - 1);
    if ({5'd0, row_c} >= 17'(MAX_DIM)) row_c = COORD_W'(MAX_DIM - 1);
    m_fx = 45'(cfg.inv_fx)   * 45'(signed'({1'b0, col_c}));
    m_sk = 45'(cfg.inv_skew) * 45'(signed'({1'b0, row_c}));
    m_fy = 45'(cfg.inv_fy)   * 45'(signed'({1'b0, row_c}));
  end

  logic               v1, k1;
  logic signed [44:0] p0, p1, p2;
  always_ff @(posedge clk) begin
    if (ce) begin
      k1 <= s_tuser;
      p0 <= m_fx;
      p1 <= m_sk;
      p2 <= m_fy;
    end
  end

  // ---------------- stage 2: homogeneous point X, Y (Z is 1.0)
  logic               v2, k2;
  logic signed [46:0] px, py;
  always_ff @(posedge clk) begin
    if (ce) begin
      k2 <= k1;
      px <= 47'(p0) + 47'(p1) + 47'(cfg.inv_cx_term);
      py <= 47'(p2) + 47'(cfg.inv_cy_term);
    end
  end

  // ---------------- stage 3: magnitudes and signs
  logic        v3, k3, nx3, ny3;
  logic [46:0] a3, b3;
  always_ff @(posedge clk) begin
    if (ce) begin
      k3  <= k2;
      nx3 <= px[46];
      ny3 <= py[46];
      a3  <= px[46] ? 47'(-px) : 47'(px);
      b3  <= py[46] ? 47'(-py) : 47'(py);
    end
  end

  // ---------------- stage 4: normalizing shift from the leading one
  logic [46:0] mx;
  logic [5:0]  top;
  always_comb begin
    mx = (a3 > b3) ? a3 : b3;
    if (mx < 47'h1000000) mx = 47'h1000000;
    top = '0;
    for (int i = 0; i < 47; i++) begin
      if (mx[i]) top = 6'(i);
    end
  end

  logic        v4, k4, nx4, ny4;
  logic [46:0] a4, b4;
  logic [4:0]  sh4;
  always_ff @(posedge clk) begin
    if (ce) begin
      k4  <= k3;
      nx4 <= nx3;
      ny4 <= ny3;
      a4  <= a3;
      b4  <= b3;
      sh4 <= 5'(top - 6'(NORM_W - 1));  // top >= 24, so never negative
    end
  end

  // ---------------- stage 5: shifted magnitudes a, b, c
  logic              v5;
  flags_t            f5;
  logic [NORM_W-1:0] a5, b5, c5;
  logic [46:0]       a_sh, b_sh;
  logic [24:0]       c_sh;
  always_comb begin
    a_sh = a4 >> sh4;
    b_sh = b4 >> sh4;
    c_sh = 25'h1000000 >> sh4;
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      f5 <= '{keep: k4, nx: nx4, ny: ny4, clamped: 1'b0};
      a5 <= a_sh[NORM_W-1:0];
      b5 <= b_sh[NORM_W-1:0];
      c5 <= c_sh[NORM_W-1:0];
    end
  end

  // ---------------- stage 6: squares, xi*c, k = 1 - xi^2
  logic [35:0]        xi2;
  logic signed [21:0] kk;
  always_comb begin
    xi2 = 36'(cfg.mirror_xi) * 36'(cfg.mirror_xi);
    kk  = 22'sd65536 - signed'({2'b00, xi2[35:16]});
  end

  logic              v6, kneg6;
  flags_t            f6;
  logic [20:0]       kmag6;
  logic [41:0]       asq, bsq;
  logic [40:0]       csq;
  logic [XC_W-1:0]   xc6;
  logic [NORM_W-1:0] a6, b6, c6;
  always_ff @(posedge clk) begin
    if (ce) begin
      f6    <= f5;
      a6    <= a5;
      b6    <= b5;
      c6    <= c5;
      asq   <= 42'(a5) * 42'(a5);
      bsq   <= 42'(b5) * 42'(b5);
      csq   <= 41'(c5) * 41'(c5);
      xc6   <= XC_W'(cfg.mirror_xi) * XC_W'(c5);
      kneg6 <= kk[21];
      kmag6 <= kk[21] ? 21'(-kk) : 21'(kk);
    end
  end

  // ---------------- stage 7: r2, z2, denominator
  logic              v7, kneg7;
  flags_t            f7;
  logic [20:0]       kmag7;
  logic [42:0]       r2;
  logic [40:0]       z27;
  logic [DEN_W-1:0]  den7;
  logic [XC_W-1:0]   xc7;
  logic [NORM_W-1:0] a7, b7, c7;
  always_ff @(posedge clk) begin
    if (ce) begin
      f7    <= f6;
      a7    <= a6;
      b7    <= b6;
      c7    <= c6;
      xc7   <= xc6;
      kneg7 <= kneg6;
      kmag7 <= kmag6;
      r2    <= 43'(asq) + 43'(bsq);
      z27   <= csq;
      den7  <= DEN_W'(asq) + DEN_W'(bsq) + DEN_W'(csq);
    end
  end

  // ---------------- stage 8: |k| * r2 as two partial products
  logic              v8, kneg8;
  flags_t            f8;
  logic [42:0]       plo;
  logic [41:0]       phi;
  logic [40:0]       z28;
  logic [DEN_W-1:0]  den8;
  logic [XC_W-1:0]   xc8;
  logic [NORM_W-1:0] a8, b8, c8;
  always_ff @(posedge clk) begin
    if (ce) begin
      f8    <= f7;
      a8    <= a7;
      b8    <= b7;
      c8    <= c7;
      xc8   <= xc7;
      den8  <= den7;
      z28   <= z27;
      kneg8 <= kneg7;
      plo   <= 43'(kmag7) * 43'(r2[21:0]);
      phi   <= 42'(kmag7) * 42'(r2[42:22]);
    end
  end

  // ---------------- stage 9: t magnitude = (|k| * r2) >> 16
  logic [63:0]       prod;
  assign prod = 64'(plo) + (64'(phi) << 22);

  logic              v9, kneg9;
  flags_t            f9;
  logic [46:0]       tmag;
  logic [40:0]       z29;
  logic [DEN_W-1:0]  den9;
  logic [XC_W-1:0]   xc9;
  logic [NORM_W-1:0] a9, b9, c9;
  always_ff @(posedge clk) begin
    if (ce) begin
      f9    <= f8;
      a9    <= a8;
      b9    <= b8;
      c9    <= c8;
      xc9   <= xc8;
      den9  <= den8;
      z29   <= z28;
      kneg9 <= kneg8;
      tmag  <= prod[62:16];
    end
  end

  // ---------------- stage 10: radicand; a negative one clamps the root to zero
  logic signed [48:0] rad;
  assign rad = kneg9 ? (49'(z29) - 49'(tmag)) : (49'(z29) + 49'(tmag));

  logic              v10;
  logic [RAD_W-1:0]  rad10;
  sqsb_t             sb10;
  always_ff @(posedge clk) begin
    if (ce) begin
      rad10 <= rad[48] ? '0 : rad[RAD_W-1:0];
      sb10  <= '{a: a9, b: b9, c: c9, den: den9, xc: xc9,
                 flags: '{keep: f9.keep, nx: f9.nx, ny: f9.ny, clamped: rad[48]}};
    end
  end

  // ---------------- square root
  logic              vq;
  logic [ROOT_W-1:0] root;
  sqsb_t             sbq;

  ops_sqrt u_sqrt (
    .clk, .rst, .ce,
    .in_vld (v10),
    .rad    (rad10),
    .in_sb  (sb10),
    .out_vld(vq),
    .root   (root),
    .out_sb (sbq)
  );

  // ---------------- numerator = xi*c + root * 2^16
  logic              vn;
  logic [NUM_W-1:0]  num;
  sqsb_t             sbn;
  always_ff @(posedge clk) begin
    if (ce) begin
      sbn <= sbq;
      num <= NUM_W'(sbq.xc) + (NUM_W'(root) << 16);
    end
  end

  // ---------------- v * num in two halves per lane
  logic [NORM_W-1:0] lane_v [LANES];
  assign lane_v[0] = sbn.a;
  assign lane_v[1] = sbn.b;
  assign lane_v[2] = sbn.c;

  logic              vm;
  logic [40:0]       ml [LANES];
  logic [40:0]       mh [LANES];
  logic [DEN_W-1:0]  denm;
  flags_t            fm;
  always_ff @(posedge clk) begin
    if (ce) begin
      denm <= sbn.den;
      fm   <= sbn.flags;
      for (int l = 0; l < LANES; l++) begin
        ml[l] <= 41'(lane_v[l]) * 41'(num[19:0]);
        mh[l] <= 41'(lane_v[l]) * 41'(num[39:20]);
      end
    end
  end

  // ---------------- dividends with half-divisor bias (round half away from zero)
  logic              vd;
  logic [DVD_W-1:0]  dvd [LANES];
  logic [DEN_W-1:0]  dend;
  flags_t            fd;
  always_ff @(posedge clk) begin
    if (ce) begin
      dend <= denm;
      fd   <= fm;
      for (int l = 0; l < LANES; l++) begin
        dvd[l] <= DVD_W'(ml[l]) + (DVD_W'(mh[l]) << 20) + DVD_W'(denm >> 1);
      end
    end
  end

  // ---------------- division
  logic             vo;
  logic [QUO_W-1:0] quo [LANES];
  flags_t           fo;

  ops_div u_div (
    .clk, .rst, .ce,
    .in_vld   (vd),
    .den      (dend),
    .dvd      (dvd),
    .in_flags (fd),
    .out_vld  (vo),
    .quo      (quo),
    .out_flags(fo)
  );

  // ---------------- signs, xi offset on z, saturation, output register
  logic signed [23:0] qx, qy, qz;
  always_comb begin
    qx = signed'({2'b00, quo[0]});
    qy = signed'({2'b00, quo[1]});
    qz = signed'({2'b00, quo[2]});
    if (fo.nx) qx = -qx;
    if (fo.ny) qy = -qy;
    qz = qz - 24'(cfg.mirror_xi);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (fo.keep) begin
        m_tdata <= {2'b00, sat18(qz), sat18(qy), sat18(qx)};
        m_tuser <= fo.clamped;
      end else begin
        m_tdata <= '0;
        m_tuser <= 1'b0;
      end
    end
  end

  // valid chain through the front stages and the tail
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0; v10 <= 1'b0;
      vn <= 1'b0; vm <= 1'b0; vd <= 1'b0; m_tvalid <= 1'b0;
    end else if (ce) begin
      v1 <= s_tvalid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
      v6 <= v5; v7 <= v6; v8 <= v7; v9 <= v8; v10 <= v9;
      vn <= vq; vm <= vn; vd <= vm; m_tvalid <= vo;
    end
  end

  // ---------------- checks
  // a stall freezes every valid bit in the front pipeline
  assert property (@(posedge clk) disable iff (rst)
    !ce |=> $stable({v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, vn, vm, vd}))
    else $error("pipeline moved during stall");

  // normalization guarantees den >= 2^40
  assert property (@(posedge clk) disable iff (rst)
    v7 && f7.keep |-> den7[DEN_W-1:40] != '0)
    else $error("denominator below normalized floor");

  // quotients stay within 21 bits
  assert property (@(posedge clk) disable iff (rst)
    vo && fo.keep |-> (quo[0][QUO_W-1] == 1'b0 && quo[1][QUO_W-1] == 1'b0 &&
                       quo[2][QUO_W-1] == 1'b0))
    else $error("quotient overflow");

  // masked pixels come out as all zeros
  assert property (@(posedge clk) disable iff (rst)
    ce && vo && !fo.keep |=> m_tdata == '0 && !m_tuser)
    else $error("masked pixel produced nonzero result");

endmodule

`default_nettype wire
